// ----- rtl/tfd_pkg.sv -----
`default_nettype none

package tfd_pkg;

    // Parser phases. Codes not listed behave as waiting for the start high byte.
    typedef enum logic [3:0] {
        PH_START_HI = 4'd0,
        PH_START_LO = 4'd1,
        PH_TYPE     = 4'd2,
        PH_SIGN_HI  = 4'd3,
        PH_SIGN_LO  = 4'd4,
        PH_DATA     = 4'd5,
        PH_ARR_LEN  = 4'd6,
        PH_ARR_TYPE = 4'd7
    } t_phase;

    // Result kinds carried in value_kind.
    localparam logic [2:0] KIND_INT   = 3'd0;
    localparam logic [2:0] KIND_FLOAT = 3'd1;
    localparam logic [2:0] KIND_EMPTY = 3'd2;
    localparam logic [2:0] KIND_BADST = 3'd3;
    localparam logic [2:0] KIND_BADTY = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_ID = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_START_CODE = 16'h0000;
    localparam logic [15:0] RST_MINUS_CODE = 16'h0000;
    localparam logic [7:0]  RST_FLOAT_CODE = 8'd5;
    localparam logic [7:0]  RST_ARRAY_CODE = 8'd6;
    localparam logic [7:0]  RST_REQUEST_ID = 8'd0;

    typedef struct packed {
        logic [15:0] start_code;
        logic [15:0] minus_code;
        logic [7:0]  float_code;
        logic [7:0]  array_code;
        logic [7:0]  request_id;
    } t_cfg;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [2:0]  value_kind;
        logic [7:0]  type_byte;
        logic        in_array;
        logic [7:0]  element_index;
        logic [7:0]  array_length;
        logic        last;
        logic [7:0]  frame_id;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/tfd_byte_if.sv -----
`default_nettype none

// Received byte channel.
interface tfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/tfd_result_if.sv -----
`default_nettype none

// Decoded result channel.
interface tfd_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic [2:0]  value_kind;
    logic [7:0]  type_byte;
    logic        in_array;
    logic [7:0]  element_index;
    logic [7:0]  array_length;
    logic        last;
    logic [7:0]  frame_id;

    modport source (output valid, output value_bits, output value_kind, output type_byte,
                    output in_array, output element_index, output array_length,
                    output last, output frame_id, input ready);
    modport sink   (input valid, input value_bits, input value_kind, input type_byte,
                    input in_array, input element_index, input array_length,
                    input last, input frame_id, output ready);
endinterface

`default_nettype wire

// ----- rtl/tfd_cfg_if.sv -----
`default_nettype none

// Configuration write channel.
interface tfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/telemetry_frame_deframer_core.sv -----
`default_nettype none

// Reply frame deframer.
// Bytes from the serial link enter on i_rx, one item per byte. The parser
// follows start word, type byte, sign word, magnitude and array header, and
// produces at most one decoded result per byte on o_res. Integer and float
// values, empty arrays, a bad start word and a bad type code each give one
// result; the final result of a frame carries last.
// Registers are written on i_cfg (index, data); the user must write them only while no
// frame is in flight, which the block does not enforce. i_cfg.ready is always high.
// Throughput is one byte per cycle while i_rx.ready is high. The result that a byte
// completes is written into the output register when that byte is accepted, or into
// the skid stage if the output register is full and not being taken.
// When the receiver stalls, a result waits in the output register and one more
// can be held in a skid stage; i_rx.ready drops only while both are full.
// Synchronous reset returns the parser to waiting for the start high byte,
// clears the output and skid stages and restores the register defaults.
module telemetry_frame_deframer_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tfd_cfg_if.sink      i_cfg,
    tfd_byte_if.sink     i_rx,
    tfd_result_if.source o_res
);
    import tfd_pkg::*;

    t_cfg    cfg;
    t_result parse_res;
    t_result out_res;
    logic    parse_valid;
    logic    space;
    logic    rx_fire;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = space;
    assign rx_fire     = i_rx.valid && space;

    tfd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    tfd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (rx_fire),
        .i_byte      (i_rx.rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (parse_valid),
        .o_res       (parse_res)
    );

    tfd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (parse_valid),
        .i_res   (parse_res),
        .o_space (space),
        .o_valid (o_res.valid),
        .o_res   (out_res),
        .i_ready (o_res.ready)
    );

    assign o_res.value_bits    = out_res.value_bits;
    assign o_res.value_kind    = out_res.value_kind;
    assign o_res.type_byte     = out_res.type_byte;
    assign o_res.in_array      = out_res.in_array;
    assign o_res.element_index = out_res.element_index;
    assign o_res.array_length  = out_res.array_length;
    assign o_res.last          = out_res.last;
    assign o_res.frame_id      = out_res.frame_id;

endmodule

`default_nettype wire

// ----- rtl/tfd_cfg.sv -----
`default_nettype none

module tfd_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr,
    input  wire logic [tfd_pkg::CFG_IDX_W-1:0]   i_index,
    input  wire logic [tfd_pkg::CFG_DATA_W-1:0]  i_data,
    output tfd_pkg::t_cfg                        o_cfg
);
    import tfd_pkg::*;

    t_cfg r_cfg;

    // Register file; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code <= RST_START_CODE;
            r_cfg.minus_code <= RST_MINUS_CODE;
            r_cfg.float_code <= RST_FLOAT_CODE;
            r_cfg.array_code <= RST_ARRAY_CODE;
            r_cfg.request_id <= RST_REQUEST_ID;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_START_CODE: r_cfg.start_code <= i_data;
                CFG_MINUS_CODE: r_cfg.minus_code <= i_data;
                CFG_FLOAT_CODE: r_cfg.float_code <= i_data[7:0];
                CFG_ARRAY_CODE: r_cfg.array_code <= i_data[7:0];
                CFG_REQUEST_ID: r_cfg.request_id <= i_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/tfd_parse.sv -----
`default_nettype none

module tfd_parse (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  tfd_pkg::t_cfg   i_cfg,
    output logic            o_res_valid,
    output tfd_pkg::t_result o_res
);
    import tfd_pkg::*;

    t_phase      r_phase,        n_phase;
    logic [7:0]  r_held,         n_held;
    logic [7:0]  r_element_type, n_element_type;
    logic [2:0]  r_bytes_left,   n_bytes_left;
    logic [31:0] r_acc,          n_acc;
    logic        r_negative,     n_negative;
    logic [7:0]  r_total,        n_total;
    logic [7:0]  r_done,         n_done;
    logic        r_array_mode,   n_array_mode;

    logic [7:0]  sel_type;
    logic        sel_float;
    logic        sel_int;
    logic [31:0] acc_shift;
    logic [2:0]  left_dec;
    logic [7:0]  done_inc;
    logic        emit;

    // Type that a new value starts with: the repeated element type, or the byte itself.
    assign sel_type  = (r_phase == PH_DATA) ? r_element_type : i_byte;
    assign sel_float = (sel_type == i_cfg.float_code);
    assign sel_int   = (sel_type >= 8'd1) && (sel_type <= 8'd4);
    assign acc_shift = {r_acc[23:0], i_byte};
    assign left_dec  = r_bytes_left - 3'd1;
    assign done_inc  = r_done + 8'd1;

    // Next parser state for the byte on the input.
    always_comb begin
        n_phase        = r_phase;
        n_held         = r_held;
        n_element_type = r_element_type;
        n_bytes_left   = r_bytes_left;
        n_acc          = r_acc;
        n_negative     = r_negative;
        n_total        = r_total;
        n_done         = r_done;
        n_array_mode   = r_array_mode;

        unique case (r_phase)
            PH_START_LO: begin
                if ({r_held, i_byte} != i_cfg.start_code) begin
                    n_phase      = PH_START_HI;
                    n_array_mode = 1'b0;
                end else begin
                    n_phase = PH_TYPE;
                end
            end

            PH_TYPE: begin
                n_array_mode = 1'b0;
                if (i_byte == i_cfg.array_code) begin
                    n_phase = PH_ARR_LEN;
                end else begin
                    n_element_type = i_byte;
                    n_acc          = '0;
                    n_negative     = 1'b0;
                    if (sel_float) begin
                        n_bytes_left = 3'd4;
                        n_phase      = PH_DATA;
                    end else if (sel_int) begin
                        n_bytes_left = i_byte[2:0];
                        n_phase      = PH_SIGN_HI;
                    end else begin
                        n_phase = PH_START_HI;
                    end
                end
            end

            PH_ARR_LEN: begin
                n_total = i_byte;
                n_done  = '0;
                n_phase = PH_ARR_TYPE;
            end

            PH_ARR_TYPE: begin
                n_element_type = i_byte;
                if (r_total == 8'd0) begin
                    n_phase      = PH_START_HI;
                    n_array_mode = 1'b0;
                end else begin
                    n_acc      = '0;
                    n_negative = 1'b0;
                    if (sel_float) begin
                        n_bytes_left = 3'd4;
                        n_phase      = PH_DATA;
                        n_array_mode = 1'b1;
                    end else if (sel_int) begin
                        n_bytes_left = i_byte[2:0];
                        n_phase      = PH_SIGN_HI;
                        n_array_mode = 1'b1;
                    end else begin
                        n_phase      = PH_START_HI;
                        n_array_mode = 1'b0;
                    end
                end
            end

            PH_SIGN_HI: begin
                n_held  = i_byte;
                n_phase = PH_SIGN_LO;
            end

            PH_SIGN_LO: begin
                n_negative = ({r_held, i_byte} == i_cfg.minus_code);
                n_acc      = '0;
                n_phase    = PH_DATA;
            end

            PH_DATA: begin
                n_acc        = acc_shift;
                n_bytes_left = left_dec;
                if (left_dec == 3'd0) begin
                    if (r_array_mode) begin
                        n_done = done_inc;
                        if (done_inc == r_total) begin
                            n_phase      = PH_START_HI;
                            n_array_mode = 1'b0;
                        end else begin
                            // Start the next element with the same type.
                            n_acc      = '0;
                            n_negative = 1'b0;
                            if (sel_float) begin
                                n_bytes_left = 3'd4;
                                n_phase      = PH_DATA;
                            end else begin
                                n_bytes_left = r_element_type[2:0];
                                n_phase      = PH_SIGN_HI;
                            end
                        end
                    end else begin
                        n_phase      = PH_START_HI;
                        n_array_mode = 1'b0;
                    end
                end
            end

            default: begin
                n_held  = i_byte;
                n_phase = PH_START_LO;
            end
        endcase
    end

    // Result caused by the byte on the input.
    always_comb begin
        emit           = 1'b0;
        o_res          = '0;
        o_res.frame_id = i_cfg.request_id;

        unique case (r_phase)
            PH_START_LO: begin
                if ({r_held, i_byte} != i_cfg.start_code) begin
                    emit             = 1'b1;
                    o_res.value_kind = KIND_BADST;
                    o_res.last       = 1'b1;
                end
            end

            PH_TYPE: begin
                if ((i_byte != i_cfg.array_code) && !sel_float && !sel_int) begin
                    emit             = 1'b1;
                    o_res.value_kind = KIND_BADTY;
                    o_res.type_byte  = i_byte;
                    o_res.last       = 1'b1;
                end
            end

            PH_ARR_TYPE: begin
                if (r_total == 8'd0) begin
                    // Empty array: element type is reported but not checked.
                    emit             = 1'b1;
                    o_res.value_kind = KIND_EMPTY;
                    o_res.type_byte  = i_byte;
                    o_res.in_array   = 1'b1;
                    o_res.last       = 1'b1;
                end else if (!sel_float && !sel_int) begin
                    emit               = 1'b1;
                    o_res.value_kind   = KIND_BADTY;
                    o_res.type_byte    = i_byte;
                    o_res.in_array     = 1'b1;
                    o_res.array_length = r_total;
                    o_res.last         = 1'b1;
                end
            end

            PH_DATA: begin
                if (left_dec == 3'd0) begin
                    emit            = 1'b1;
                    o_res.type_byte = r_element_type;
                    if (r_element_type == i_cfg.float_code) begin
                        o_res.value_bits = acc_shift;
                        o_res.value_kind = KIND_FLOAT;
                    end else begin
                        o_res.value_bits = r_negative ? (~acc_shift + 32'd1) : acc_shift;
                        o_res.value_kind = KIND_INT;
                    end
                    if (r_array_mode) begin
                        o_res.in_array      = 1'b1;
                        o_res.element_index = r_done;
                        o_res.array_length  = r_total;
                        o_res.last          = (done_inc == r_total);
                    end else begin
                        o_res.last = 1'b1;
                    end
                end
            end

            default: begin
            end
        endcase
    end

    assign o_res_valid = i_fire && emit;

    // Parser state advances on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_START_HI;
            r_held         <= '0;
            r_element_type <= '0;
            r_bytes_left   <= '0;
            r_acc          <= '0;
            r_negative     <= 1'b0;
            r_total        <= '0;
            r_done         <= '0;
            r_array_mode   <= 1'b0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_held         <= n_held;
            r_element_type <= n_element_type;
            r_bytes_left   <= n_bytes_left;
            r_acc          <= n_acc;
            r_negative     <= n_negative;
            r_total        <= n_total;
            r_done         <= n_done;
            r_array_mode   <= n_array_mode;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tfd_outbuf.sv -----
`default_nettype none

module tfd_outbuf (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  tfd_pkg::t_result  i_res,
    output logic              o_space,
    output logic              o_valid,
    output tfd_pkg::t_result  o_res,
    input  wire logic         i_ready
);
    import tfd_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

    // Valid flags of the output register and the skid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop && r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (i_push && r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end
            if (i_push || (pop && r_skid_valid)) begin
                r_main_valid <= 1'b1;
            end else if (pop) begin
                r_main_valid <= 1'b0;
            end
        end
    end

    // Payload moves: new result into the free slot, skid forward on a pop.
    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_main <= r_skid;
        end else if (i_push && (!r_main_valid || pop)) begin
            r_main <= i_res;
        end
        if (i_push && r_main_valid && !pop) begin
            r_skid <= i_res;
        end
    end

endmodule

`default_nettype wire

// ----- tb/tfd_tb_pkg.sv -----
`timescale 1ns / 100ps

package tfd_tb_pkg;

    import tfd_pkg::*;

    // Tracks the parser state for every accepted byte item and holds the
    // decoded values that the block still owes.
    class value_scoreboard;
        t_cfg        cfg;
        t_phase      parse_phase;
        logic [7:0]  held_byte;
        logic [7:0]  frame_type;
        logic [7:0]  elem_type;
        logic [2:0]  bytes_left;
        logic [31:0] shift_acc;
        logic        negate;
        logic        in_array;
        logic [7:0]  elems_total;
        logic [7:0]  elems_done;
        t_result     pending_values[$];
        int unsigned mismatches;

        function new();
            cfg.start_code = RST_START_CODE;
            cfg.minus_code = RST_MINUS_CODE;
            cfg.float_code = RST_FLOAT_CODE;
            cfg.array_code = RST_ARRAY_CODE;
            cfg.request_id = RST_REQUEST_ID;
            parse_phase = PH_START_HI;
            held_byte = '0;
            frame_type = '0;
            elem_type = '0;
            bytes_left = '0;
            shift_acc = '0;
            negate = 1'b0;
            in_array = 1'b0;
            elems_total = '0;
            elems_done = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_START_CODE: cfg.start_code = data;
                CFG_MINUS_CODE: cfg.minus_code = data;
                CFG_FLOAT_CODE: cfg.float_code = data[7:0];
                CFG_ARRAY_CODE: cfg.array_code = data[7:0];
                CFG_REQUEST_ID: cfg.request_id = data[7:0];
                default: ;
            endcase
        endfunction

        // A type code that opens a value: the float code or an integer length.
        function bit is_value_type(logic [7:0] t);
            return (t == cfg.float_code) || (t >= 8'd1 && t <= 8'd4);
        endfunction

        function int pending();
            return pending_values.size();
        endfunction

        function void add_expected(logic [31:0] bits, logic [2:0] kind, logic [7:0] tcode,
                                   logic arr, logic [7:0] idx, logic [7:0] len, logic lst);
            t_result r;
            r.value_bits = bits;
            r.value_kind = kind;
            r.type_byte = tcode;
            r.in_array = arr;
            r.element_index = idx;
            r.array_length = len;
            r.last = lst;
            r.frame_id = cfg.request_id;
            pending_values.push_back(r);
        endfunction

        function void restart();
            parse_phase = PH_START_HI;
            in_array = 1'b0;
        endfunction

        // Sets up the decode of one value; a float takes no sign word.
        function bit open_value(logic [7:0] t);
            elem_type = t;
            shift_acc = '0;
            negate = 1'b0;
            if (t == cfg.float_code) begin
                bytes_left = 3'd4;
                parse_phase = PH_DATA;
                return 1'b1;
            end
            if (t >= 8'd1 && t <= 8'd4) begin
                bytes_left = t[2:0];
                parse_phase = PH_SIGN_HI;
                return 1'b0 == 1'b0;
            end
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [31:0] bits;
            logic [2:0]  kind;
            logic [7:0]  next_done;
            case (parse_phase)
                PH_START_LO: begin
                    if ({held_byte, b} != cfg.start_code) begin
                        add_expected('0, KIND_BADST, '0, 1'b0, '0, '0, 1'b1);
                        restart();
                    end else begin
                        parse_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    frame_type = b;
                    in_array = 1'b0;
                    if (b == cfg.array_code) begin
                        parse_phase = PH_ARR_LEN;
                    end else if (!open_value(b)) begin
                        add_expected('0, KIND_BADTY, b, 1'b0, '0, '0, 1'b1);
                        restart();
                    end
                end
                PH_ARR_LEN: begin
                    elems_total = b;
                    elems_done = '0;
                    parse_phase = PH_ARR_TYPE;
                end
                PH_ARR_TYPE: begin
                    elem_type = b;
                    // An empty array ends the frame without looking at the type.
                    if (elems_total == 8'd0) begin
                        add_expected('0, KIND_EMPTY, b, 1'b1, '0, '0, 1'b1);
                        restart();
                    end else if (!open_value(b)) begin
                        add_expected('0, KIND_BADTY, b, 1'b1, '0, elems_total, 1'b1);
                        restart();
                    end else begin
                        in_array = 1'b1;
                    end
                end
                PH_SIGN_HI: begin
                    held_byte = b;
                    parse_phase = PH_SIGN_LO;
                end
                PH_SIGN_LO: begin
                    negate = ({held_byte, b} == cfg.minus_code);
                    shift_acc = '0;
                    parse_phase = PH_DATA;
                end
                PH_DATA: begin
                    shift_acc = {shift_acc[23:0], b};
                    bytes_left = bytes_left - 3'd1;
                    if (bytes_left == 3'd0) begin
                        if (elem_type == cfg.float_code) begin
                            bits = shift_acc;
                            kind = KIND_FLOAT;
                        end else begin
                            // Negation wraps, so the most negative value stays put.
                            bits = negate ? (32'd0 - shift_acc) : shift_acc;
                            kind = KIND_INT;
                        end
                        if (in_array) begin
                            next_done = elems_done + 8'd1;
                            add_expected(bits, kind, elem_type, 1'b1, elems_done, elems_total,
                                         next_done == elems_total);
                            elems_done = next_done;
                            if (elems_done == elems_total) begin
                                restart();
                            end else begin
                                void'(open_value(elem_type));
                            end
                        end else begin
                            add_expected(bits, kind, elem_type, 1'b0, '0, '0, 1'b1);
                            restart();
                        end
                    end
                end
                default: begin
                    held_byte = b;
                    parse_phase = PH_START_LO;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        // Compares one delivered result with the oldest value still owed.
        function void check_value(t_result got);
            t_result want;
            if (pending_values.size() == 0) begin
                $error("result with nothing owed: value_bits %0h, value_kind %0d",
                       got.value_bits, got.value_kind);
                mismatches++;
                return;
            end
            want = pending_values.pop_front();
            compare_field("value_bits", want.value_bits, got.value_bits);
            compare_field("value_kind", 32'(want.value_kind), 32'(got.value_kind));
            compare_field("type_byte", 32'(want.type_byte), 32'(got.type_byte));
            compare_field("in_array", 32'(want.in_array), 32'(got.in_array));
            compare_field("element_index", 32'(want.element_index),
                          32'(got.element_index));
            compare_field("array_length", 32'(want.array_length), 32'(got.array_length));
            compare_field("last", 32'(want.last), 32'(got.last));
            compare_field("frame_id", 32'(want.frame_id), 32'(got.frame_id));
        endfunction
    endclass

endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import tfd_pkg::*;
    import tfd_tb_pkg::*;

    localparam int NUM_PHASES = 6;
    localparam int BYTES_PER_PHASE = 250;
    localparam int STALL_LIMIT = 2000;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_RUNS
    } t_ready_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tfd_cfg_if    cfg_bus ();
    tfd_byte_if   rx_bus ();
    tfd_result_if res_bus ();

    value_scoreboard deframer_sb = new();

    int          burst_left = 0;
    int unsigned bytes_sent = 0;
    int unsigned quiet_cycles = 0;
    t_cfg        phase_cfgs [NUM_PHASES];

    telemetry_frame_deframer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_rx    (rx_bus),
        .o_res   (res_bus)
    );

    // Clock with a 10 ns period.
    always #5 i_clk = ~i_clk;

    // Receiver: ready follows one of four stall patterns, redrawn at random.
    initial begin
        t_ready_mode ready_mode;
        int          cyc;
        int          run_left;
        logic        run_ready;
        ready_mode = READY_ALWAYS;
        cyc = 0;
        run_left = 0;
        run_ready = 1'b1;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 300 == 0) begin
                ready_mode = t_ready_mode'($urandom_range(0, 3));
            end
            case (ready_mode)
                READY_ALWAYS: res_bus.ready <= 1'b1;
                READY_COIN: res_bus.ready <= 1'($urandom_range(0, 1));
                READY_PERIODIC: res_bus.ready <= (cyc % 4 == 0);
                default: begin
                    if (run_left == 0) begin
                        run_ready = ~run_ready;
                        run_left = $urandom_range(1, 24);
                    end
                    run_left--;
                    res_bus.ready <= run_ready;
                end
            endcase
        end
    end

    // Check every result item taken by the receiver.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got.value_bits = res_bus.value_bits;
            got.value_kind = res_bus.value_kind;
            got.type_byte = res_bus.type_byte;
            got.in_array = res_bus.in_array;
            got.element_index = res_bus.element_index;
            got.array_length = res_bus.array_length;
            got.last = res_bus.last;
            got.frame_id = res_bus.frame_id;
            deframer_sb.check_value(got);
        end
    end

    // Count cycles in which no channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: the run is stuck if nothing moves for too long.
    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Offers one byte item, in bursts with random gaps between them.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            rx_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 20);
        end
        burst_left--;
        rx_bus.valid <= 1'b1;
        rx_bus.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_bus.ready) @(posedge i_clk);
        deframer_sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [15:0] w);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
    endtask

    // Sends one value of a valid type: sign word for integers, then the data bytes.
    task automatic send_value(input logic [7:0] t);
        int         n;
        int         pat;
        logic [7:0] fill;
        if (t == deframer_sb.cfg.float_code) begin
            n = 4;
        end else begin
            n = int'(t);
            if ($urandom_range(0, 1) == 1) begin
                send_word(deframer_sb.cfg.minus_code);
            end else begin
                send_word(16'($urandom_range(0, 65535)));
            end
        end
        pat = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
            case (pat)
                0: fill = 8'h00;
                1: fill = 8'hFF;
                2: fill = (i == 0) ? 8'h80 : 8'h00;
                3: fill = (i == n - 1) ? 8'h01 : 8'h00;
                default: fill = 8'($urandom_range(0, 255));
            endcase
            send_byte(fill);
        end
    endtask

    // Feeds zeros until the parser is back at the start word.
    task automatic finish_frame();
        while (deframer_sb.parse_phase != PH_START_HI) send_byte(8'h00);
    endtask

    // One random frame: mostly well formed, the rest bad starts, noise and cut frames.
    task automatic send_frame();
        int         pick;
        logic [7:0] t;
        logic [7:0] len;
        logic [7:0] et;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            send_word(deframer_sb.cfg.start_code);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                t = deframer_sb.cfg.array_code;
            end else if (pick < 50) begin
                t = deframer_sb.cfg.float_code;
            end else if (pick < 85) begin
                t = 8'($urandom_range(1, 4));
            end else begin
                t = 8'($urandom_range(0, 255));
            end
            send_byte(t);
            // Array code wins over the float code, which wins over integer lengths.
            if (t == deframer_sb.cfg.array_code) begin
                len = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 5));
                send_byte(len);
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    et = 8'($urandom_range(0, 255));
                end else if (pick < 40) begin
                    et = deframer_sb.cfg.float_code;
                end else begin
                    et = 8'($urandom_range(1, 4));
                end
                send_byte(et);
                if (len != 8'd0 && deframer_sb.is_value_type(et)) begin
                    repeat (len) send_value(et);
                end
            end else if (deframer_sb.is_value_type(t)) begin
                send_value(t);
            end
        end else if (pick < 82) begin
            send_word(deframer_sb.cfg.start_code ^ (16'd1 << $urandom_range(0, 15)));
        end else if (pick < 92) begin
            repeat (2 * $urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_word(deframer_sb.cfg.start_code);
            send_byte(8'($urandom_range(1, 4)));
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
            finish_frame();
        end
    endtask

    // Waits until every owed result has been taken and the block has settled.
    task automatic drain();
        rx_bus.valid <= 1'b0;
        burst_left = 0;
        while (deframer_sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all five registers, one item per register.
    task automatic program_registers(input t_cfg c);
        logic [CFG_IDX_W-1:0] idx_list [5];
        logic [15:0]          data_list [5];
        idx_list = '{CFG_START_CODE, CFG_MINUS_CODE, CFG_FLOAT_CODE, CFG_ARRAY_CODE,
                     CFG_REQUEST_ID};
        data_list = '{c.start_code, c.minus_code, {8'h00, c.float_code},
                      {8'h00, c.array_code}, {8'h00, c.request_id}};
        for (int k = 0; k < 5; k++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx_list[k];
            cfg_bus.data <= data_list[k];
            @(posedge i_clk);
            while (!cfg_bus.ready) @(posedge i_clk);
            deframer_sb.write_reg(idx_list[k], data_list[k]);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // Main sequence: reset, directed frames, then random frames per register setting.
    initial begin
        logic [7:0]  directed_bytes[$];
        int unsigned phase_start;
        i_rst_n <= 1'b0;
        rx_bus.valid <= 1'b0;
        rx_bus.rx_byte <= 8'h00;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= CFG_START_CODE;
        cfg_bus.data <= 16'h0000;

        phase_cfgs[0] = '{start_code: RST_START_CODE, minus_code: RST_MINUS_CODE,
                          float_code: RST_FLOAT_CODE, array_code: RST_ARRAY_CODE,
                          request_id: RST_REQUEST_ID};
        phase_cfgs[1] = '{start_code: 16'hFFFF, minus_code: 16'hFFFF, float_code: 8'hFF,
                          array_code: 8'h00, request_id: 8'hFF};
        phase_cfgs[2] = '{start_code: 16'hA55A, minus_code: 16'h8000, float_code: 8'h01,
                          array_code: 8'h05, request_id: 8'h3C};
        phase_cfgs[3] = '{start_code: 16'h1234, minus_code: 16'h0001, float_code: 8'h03,
                          array_code: 8'h03, request_id: 8'h7F};
        phase_cfgs[4] = '{start_code: 16'($urandom_range(0, 65535)),
                          minus_code: 16'($urandom_range(0, 65535)),
                          float_code: 8'($urandom_range(0, 255)),
                          array_code: 8'($urandom_range(0, 255)),
                          request_id: 8'($urandom_range(0, 255))};
        phase_cfgs[5] = '{start_code: 16'h0000, minus_code: 16'h0000, float_code: 8'h00,
                          array_code: 8'hFF, request_id: 8'h00};

        // Directed frames under the reset settings: start word 0, minus word 0,
        // float code 5, array code 6.
        directed_bytes = {
            8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h7F,                // int8, positive
            8'h00, 8'h00, 8'h04, 8'h12, 8'h34, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, // most negative
            8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,  // minus one
            8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00,         // float zero
            8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h01,         // float denormal
            8'h00, 8'h00, 8'h06, 8'h00, 8'hEE,                       // empty array
            8'h00, 8'h00, 8'h06, 8'h02, 8'h02, 8'h00, 8'h00, 8'h00, 8'h07,
            8'hAB, 8'hCD, 8'h80, 8'h00,
            8'h00, 8'h00, 8'h06, 8'h01, 8'h05, 8'h3F, 8'h80, 8'h00, 8'h00,
            8'h12, 8'h34,                                            // bad start word
            8'h00, 8'h00, 8'h00,                                     // bad frame types
            8'h00, 8'h00, 8'hFF,
            8'h00, 8'h00, 8'h06, 8'h03, 8'h09                        // bad element type
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain();
                program_registers(phase_cfgs[p]);
            end else begin
                foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < BYTES_PER_PHASE) send_frame();
            finish_frame();
        end
        drain();

        if (deframer_sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
